>>> hw/rtl/efp_pkg.sv
// Package for the escape-time fractal pixel engine: sizes, register indexes,
// controller states and the command and status bundles between the controller
// and the datapath. No dependencies.
package efp_pkg;

  localparam int PALETTE_DEPTH   = 8192;
  localparam int COORD_FRAC_BITS = 24;
  localparam int PAL_AW          = $clog2(PALETTE_DEPTH);
  localparam int PAL_W           = 24;

  // Orbit components are held with a few bits of headroom above the saturated magnitude.
  localparam int ZW = 34;

  // Escape threshold |z|^2 > 20, expressed with twice the coordinate fraction bits.
  localparam logic [63:0] ESC_LIMIT = 64'd20 << (2 * COORD_FRAC_BITS);
  localparam logic [30:0] MAG_MAX   = {31{1'b1}};

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_ITER    = 3'd0;
  localparam logic [2:0] REG_REAL_ORIGIN = 3'd1;
  localparam logic [2:0] REG_REAL_STEP   = 3'd2;
  localparam logic [2:0] REG_IMAG_ORIGIN = 3'd3;
  localparam logic [2:0] REG_IMAG_STEP   = 3'd4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_ADD,
    ST_IT_MUL,
    ST_IT_CHK,
    ST_NORM_Q,
    ST_NORM_L,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic pal_write;
    logic start;
    logic calc_c;
    logic iter_mul;
    logic iter_upd;
    logic norm_load_q;
    logic norm_step;
    logic norm_load_l;
    logic calc_s;
    logic calc_s_limit;
    logic rd_first;
    logic rd_second;
    logic cap_e2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic escaped;
    logic norm_done;
  } status_t;

endpackage

>>> hw/rtl/efp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module efp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/efp_ctrl.sv
// Controller of the fractal pixel engine: sequences coordinate setup, the
// orbit loop, the log normalization, palette reads and the output register.
// Depends on efp_pkg.
module efp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  output logic              out_valid,
  input  logic              out_ready,
  input  efp_pkg::status_t  status,
  output efp_pkg::cmd_t     cmd
);

  efp_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == efp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= efp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      efp_pkg::ST_IDLE: begin
        if (in_valid && req_type == efp_pkg::REQ_RENDER) begin
          state_next = efp_pkg::ST_C_ADD;
        end
      end
      efp_pkg::ST_C_ADD:   state_next = efp_pkg::ST_IT_MUL;
      efp_pkg::ST_IT_MUL:  state_next = efp_pkg::ST_IT_CHK;
      efp_pkg::ST_IT_CHK: begin
        if (!status.iter_done) begin
          state_next = efp_pkg::ST_IT_MUL;
        end else if (status.escaped) begin
          state_next = efp_pkg::ST_NORM_Q;
        end else begin
          state_next = efp_pkg::ST_RD1;
        end
      end
      efp_pkg::ST_NORM_Q: begin
        if (status.norm_done) begin
          state_next = efp_pkg::ST_NORM_L;
        end
      end
      efp_pkg::ST_NORM_L: begin
        if (status.norm_done) begin
          state_next = efp_pkg::ST_RD1;
        end
      end
      efp_pkg::ST_RD1:     state_next = efp_pkg::ST_RD2;
      efp_pkg::ST_RD2:     state_next = efp_pkg::ST_RD3;
      efp_pkg::ST_RD3:     state_next = efp_pkg::ST_MIX;
      efp_pkg::ST_MIX: begin
        if (out_free) begin
          state_next = efp_pkg::ST_IDLE;
        end
      end
      default:             state_next = efp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      efp_pkg::ST_IDLE: begin
        cmd.pal_write = in_valid && req_type == efp_pkg::REQ_LOAD;
        cmd.start     = in_valid && req_type == efp_pkg::REQ_RENDER;
      end
      efp_pkg::ST_C_ADD:   cmd.calc_c = 1'b1;
      efp_pkg::ST_IT_MUL:  cmd.iter_mul = 1'b1;
      efp_pkg::ST_IT_CHK: begin
        cmd.iter_upd     = !status.iter_done;
        cmd.norm_load_q  = status.iter_done && status.escaped;
        cmd.calc_s_limit = status.iter_done && !status.escaped;
      end
      efp_pkg::ST_NORM_Q: begin
        cmd.norm_step   = !status.norm_done;
        cmd.norm_load_l = status.norm_done;
      end
      efp_pkg::ST_NORM_L: begin
        cmd.norm_step = !status.norm_done;
        cmd.calc_s    = status.norm_done;
      end
      efp_pkg::ST_RD1:     cmd.rd_first = 1'b1;
      efp_pkg::ST_RD2:     cmd.rd_second = 1'b1;
      efp_pkg::ST_RD3:     cmd.cap_e2 = 1'b1;
      efp_pkg::ST_MIX:     cmd.load_out = out_free;
      default:             cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/efp_datapath.sv
// Datapath of the fractal pixel engine: configuration registers, coordinate
// mapping, orbit arithmetic, shared normalizer for the log steps, palette RAM
// and color blend. Depends on efp_pkg and efp_ram.
module efp_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic [11:0]              pixel_x,
  input  logic [11:0]              pixel_y,
  input  logic [12:0]              entry_index,
  input  logic [7:0]               entry_red,
  input  logic [7:0]               entry_green,
  input  logic [7:0]               entry_blue,
  input  efp_pkg::cmd_t            cmd,
  output efp_pkg::status_t         status,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue,
  output logic [12:0]              escape_count
);

  logic [12:0]        iter_cap;
  logic signed [31:0] real_origin, real_step, imag_origin, imag_step;

  logic signed [44:0] prod_re, prod_im;
  logic signed [31:0] cr, ci;
  logic signed [45:0] sum_re, sum_im;

  logic signed [efp_pkg::ZW-1:0] zx, zy;
  logic [12:0]        iter;
  logic [30:0]        mx, my;
  logic [61:0]        sx, sy, pxy;
  logic               pxy_neg;
  logic [63:0]        q;
  logic signed [63:0] diff, xy, nx, ny;

  logic [63:0]        norm;
  logic [5:0]         ncnt;
  logic               nzero;
  logic [5:0]         nexp;
  logic [15:0]        nfrac;
  logic signed [6:0]  l_exp, nu_exp;
  logic signed [22:0] l_val, nu_val;
  logic signed [14:0] nu8;
  logic signed [23:0] s_raw;
  logic [21:0]        s_val;
  logic [13:0]        n_idx;
  logic [14:0]        n_next;
  logic [7:0]         t_frac;

  logic [efp_pkg::PAL_AW-1:0] raddr;
  logic [efp_pkg::PAL_W-1:0]  rdata, e1, e2;
  logic                       pal_we;

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] t);
    logic [16:0] acc;
    acc = 17'(a * (9'd256 - 9'(t))) + 17'(b * t);
    return acc[15:8];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cap    <= 13'd1000;
      real_origin <= -32'sd33554432;
      real_step   <= 32'sd30583;
      imag_origin <= -32'sd16777216;
      imag_step   <= 32'sd31069;
    end else if (cfg_write) begin
      unique case (cfg_index)
        efp_pkg::REG_MAX_ITER:    iter_cap    <= cfg_data[12:0];
        efp_pkg::REG_REAL_ORIGIN: real_origin <= cfg_data;
        efp_pkg::REG_REAL_STEP:   real_step   <= cfg_data;
        efp_pkg::REG_IMAG_ORIGIN: imag_origin <= cfg_data;
        efp_pkg::REG_IMAG_STEP:   imag_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coordinate mapping: product first, then add and saturate.
  assign sum_re = 46'(real_origin) + 46'(prod_re);
  assign sum_im = 46'(imag_origin) + 46'(prod_im);

  // Orbit magnitudes, saturated so the squares stay within 62 bits.
  always_comb begin
    logic [efp_pkg::ZW-1:0] ax, ay;
    ax = zx[efp_pkg::ZW-1] ? efp_pkg::ZW'(-zx) : efp_pkg::ZW'(zx);
    ay = zy[efp_pkg::ZW-1] ? efp_pkg::ZW'(-zy) : efp_pkg::ZW'(zy);
    mx = (ax > efp_pkg::ZW'(efp_pkg::MAG_MAX)) ? efp_pkg::MAG_MAX : ax[30:0];
    my = (ay > efp_pkg::ZW'(efp_pkg::MAG_MAX)) ? efp_pkg::MAG_MAX : ay[30:0];
  end

  assign q    = {2'b00, sx} + {2'b00, sy};
  assign diff = $signed({2'b00, sx}) - $signed({2'b00, sy});
  assign xy   = pxy_neg ? -$signed({2'b00, pxy}) : $signed({2'b00, pxy});
  assign nx   = (diff >>> efp_pkg::COORD_FRAC_BITS) + 64'(cr);
  assign ny   = ((xy <<< 1) >>> efp_pkg::COORD_FRAC_BITS) + 64'(ci);

  assign status.iter_done = (q > efp_pkg::ESC_LIMIT) || (iter >= iter_cap);
  assign status.escaped   = iter < iter_cap;
  assign status.norm_done = norm[63] || nzero;

  // Mitchell log2 pieces from the normalized word.
  assign nzero  = (norm == 64'd0);
  assign nexp   = 6'd63 - ncnt;
  assign nfrac  = norm[62:47];
  assign l_exp  = $signed({1'b0, nexp}) - $signed(7'(2 * efp_pkg::COORD_FRAC_BITS));
  assign l_val  = nzero ? 23'sd0 : $signed({l_exp, nfrac});
  assign nu_exp = nzero ? -7'sd1 : $signed({1'b0, nexp}) - 7'sd17;
  assign nu_val = $signed({nu_exp, (nzero ? 16'd0 : nfrac)});
  assign nu8    = 15'(nu_val >>> 8);
  assign s_raw  = $signed({2'b00, 14'(iter) + 14'd1, 8'd0}) - 24'(nu8);

  assign n_idx  = s_val[21:8];
  assign t_frac = s_val[7:0];
  assign n_next = 15'(n_idx) + 15'd1;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      prod_re <= $signed({1'b0, pixel_x}) * real_step;
      prod_im <= $signed({1'b0, pixel_y}) * imag_step;
      zx      <= '0;
      zy      <= '0;
      iter    <= '0;
    end
    if (cmd.calc_c) begin
      cr <= (sum_re > 46'sd2147483647) ? 32'sh7FFFFFFF :
            (sum_re < -46'sd2147483648) ? 32'sh80000000 : 32'(sum_re);
      ci <= (sum_im > 46'sd2147483647) ? 32'sh7FFFFFFF :
            (sum_im < -46'sd2147483648) ? 32'sh80000000 : 32'(sum_im);
    end
    if (cmd.iter_mul) begin
      sx      <= mx * mx;
      sy      <= my * my;
      pxy     <= mx * my;
      pxy_neg <= zx[efp_pkg::ZW-1] ^ zy[efp_pkg::ZW-1];
    end
    if (cmd.iter_upd) begin
      zx   <= efp_pkg::ZW'(nx);
      zy   <= efp_pkg::ZW'(ny);
      iter <= iter + 13'd1;
    end
    if (cmd.norm_load_q) begin
      norm <= q;
      ncnt <= '0;
    end else if (cmd.norm_load_l) begin
      norm <= 64'(l_val);
      ncnt <= '0;
    end else if (cmd.norm_step) begin
      norm <= {norm[62:0], 1'b0};
      ncnt <= ncnt + 6'd1;
    end
    if (cmd.calc_s) begin
      s_val <= s_raw[23] ? 22'd0 : s_raw[21:0];
    end else if (cmd.calc_s_limit) begin
      s_val <= {1'b0, iter_cap, 8'd0};
    end
    if (cmd.rd_second) begin
      e1 <= rdata;
    end
    if (cmd.cap_e2) begin
      e2 <= (n_next > 15'(iter_cap)) ? e1 : rdata;
    end
    if (cmd.load_out) begin
      red          <= blend(e1[23:16], e2[23:16], t_frac);
      green        <= blend(e1[15:8],  e2[15:8],  t_frac);
      blue         <= blend(e1[7:0],   e2[7:0],   t_frac);
      escape_count <= iter;
    end
  end

  // Palette reads saturate to the last entry.
  always_comb begin
    logic [14:0] idx;
    idx   = cmd.rd_second ? n_next : 15'(n_idx);
    raddr = (32'(idx) >= efp_pkg::PALETTE_DEPTH) ?
            efp_pkg::PAL_AW'(efp_pkg::PALETTE_DEPTH - 1) : efp_pkg::PAL_AW'(idx);
  end

  assign pal_we = cmd.pal_write && (32'(entry_index) < efp_pkg::PALETTE_DEPTH);

  efp_ram #(
    .WIDTH (efp_pkg::PAL_W),
    .DEPTH (efp_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (efp_pkg::PAL_AW'(entry_index)),
    .wdata ({entry_red, entry_green, entry_blue}),
    .re    (cmd.rd_first || cmd.rd_second),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

>>> hw/rtl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel engine with smooth coloring.
// Depends on efp_pkg, efp_ctrl and efp_datapath.
//
// Usage: the input channel (in_valid/in_ready) carries two kinds of items.
// A load item (req_type 0) writes one palette entry when it is taken and
// gives no result. A render item (req_type 1) maps the pixel to a point c,
// iterates z = z^2 + c, smooths the escape count with Mitchell log2
// approximations and blends two palette entries into one result item.
// After a render item is taken, the engine adds the origin, then runs escape
// tests (squares, then test and update) until the orbit escapes or reaches
// iter_cap; an escaping pixel then runs bit-serial normalization for the two
// log steps; palette reads and the blend follow. The next item is taken only
// once the engine is back in idle, so one render item is in work.
// Reset restores the register defaults; the palette is not cleared and must
// be loaded before rendering. A finished result sits in an output register;
// when the receiver stalls, the engine holds the next result until that
// register drains. Configuration is written through cfg_write/cfg_index/
// cfg_data; the user must write it only while idle, as the block does not
// enforce this.
module escape_time_fractal_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [12:0] entry_index,
  input  logic [7:0]  entry_red,
  input  logic [7:0]  entry_green,
  input  logic [7:0]  entry_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [12:0] escape_count
);

  efp_pkg::cmd_t    cmd;
  efp_pkg::status_t status;

  // The controller steps through the phases of one item.
  efp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the registers, arithmetic and palette memory.
  efp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .entry_index  (entry_index),
    .entry_red    (entry_red),
    .entry_green  (entry_green),
    .entry_blue   (entry_blue),
    .cmd          (cmd),
    .status       (status),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .escape_count (escape_count)
  );

endmodule
